### sv/sv39_pkg.sv
package sv39_pkg;

    localparam int TABLE_PAGES      = 16;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int MAX_RUN          = 64;
    localparam int PAGE_W  = $clog2(TABLE_PAGES);
    localparam int IDX_W   = 9;
    localparam int ADDR_W  = PAGE_W + IDX_W;
    localparam int DEPTH   = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int NFP_W   = $clog2(TABLE_PAGES + 1);

    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_UNMAP  = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_REMAP    = 3'd2;
    localparam logic [2:0] ST_UNMAPPED = 3'd3;
    localparam logic [2:0] ST_NOTLEAF  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_HUGE     = 3'd6;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_VA_LIMIT  = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [26:0] va_page;
        logic [43:0] pa_page;
        logic [7:0]  perm;
        logic        free_it;
        logic [6:0]  page_count;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] entry_value;
        logic        freed_valid;
        logic [43:0] freed_page;
        logic        last;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_RD, S_WAIT, S_EVAL, S_OUT
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       wdata;
    } t_mem_req;

endpackage

### sv/sv39_ram.sv
module sv39_ram (
    input  logic                      i_clk,
    input  sv39_pkg::t_mem_req        i_req,
    output logic [63:0]               o_rdata
);
    import sv39_pkg::*;

    logic [63:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

### sv/sv39_page_table_map_unmap.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | i_in_valid/o_in_ready   | i_in (t_in)
// out     | out | o_out_valid/i_out_ready | o_out (t_out)
// cfg     | in  | i_cfg_we               | i_cfg_index, i_cfg_data
// After reset a clearing pass writes all 8192 table entries, one per cycle;
// no transaction is accepted until it ends.
// Each page walks up to three table levels, each in address, read and evaluate steps;
// the leaf write shares the evaluate cycle, then an output step follows; each
// transaction also passes through accept and range-check steps.
// One item at a time; a stalled output holds the walk in place.
module sv39_page_table_map_unmap (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sv39_pkg::t_in        i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sv39_pkg::t_out       o_out,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [43:0]          i_cfg_data
);
    import sv39_pkg::*;

    t_state r_state, n_state;
    t_in    r_item, n_item;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [NFP_W-1:0]  r_nfp, n_nfp;
    logic [1:0]        r_lvl, n_lvl;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [6:0]        r_i, n_i;
    logic [43:0]       r_base;
    logic [27:0]       r_lim;
    t_out              r_out, n_out;
    logic              r_ovalid, n_ovalid;
    t_mem_req          req;
    logic [63:0]       rdata;

    logic [26:0] va;
    logic [8:0]  idx;
    logic [43:0] e_ppn, rel;
    logic [27:0] va_end;

    sv39_ram u_ram (.i_clk(i_clk), .i_req(req), .o_rdata(rdata));

    assign va     = r_item.va_page + 27'(r_i);
    assign va_end = 28'(r_item.va_page) + 28'(r_item.page_count);
    assign e_ppn  = rdata[53:10];
    assign rel    = e_ppn - r_base;
    always_comb begin
        unique case (r_lvl)
            2'd2:    idx = va[26:18];
            2'd1:    idx = va[17:9];
            default: idx = va[8:0];
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 44'd524288;
            r_lim  <= 28'd67108864;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_POOL_BASE) r_base <= i_cfg_data;
            else                              r_lim  <= i_cfg_data[27:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_nfp    <= NFP_W'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_nfp    <= n_nfp;
            r_ovalid <= n_ovalid;
        end
        r_item <= n_item;
        r_lvl  <= n_lvl;
        r_page <= n_page;
        r_i    <= n_i;
        r_out  <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_nfp    = r_nfp;
        n_ovalid = r_ovalid && !i_out_ready;
        n_item   = r_item;
        n_lvl    = r_lvl;
        n_page   = r_page;
        n_i      = r_i;
        n_out    = r_out;
        req.we    = 1'b0;
        req.addr  = {r_page, idx};
        req.wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                req.we   = 1'b1;
                req.addr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_item  = i_in;
                    n_state = (i_in.op == 2'd3) ? S_IDLE : S_CHECK;
                end
            end
            S_CHECK: begin
                n_i    = '0;
                n_lvl  = 2'd2;
                n_page = '0;
                if (r_item.page_count == 7'd0 || r_item.page_count > 7'(MAX_RUN)
                        || 28'(r_item.va_page) >= r_lim || va_end > r_lim) begin
                    n_out    = '{ST_RANGE, 64'd0, 1'b0, 44'd0, 1'b1};
                    n_ovalid = 1'b1;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (r_lvl != 2'd0) begin
                    if (rdata[0]) begin
                        if (rdata[3:1] != 3'd0) begin
                            n_out = '{ST_HUGE, 64'd0, 1'b0, 44'd0, 1'b1};
                            n_ovalid = 1'b1;
                        end else begin
                            n_page  = rel[PAGE_W-1:0];
                            n_lvl   = r_lvl - 1'b1;
                            n_state = S_RD;
                        end
                    end else if (r_item.op != OP_MAP) begin
                        n_out = '{ST_UNMAPPED, 64'd0, 1'b0, 44'd0, 1'b1};
                        n_ovalid = 1'b1;
                    end else if (r_nfp >= NFP_W'(TABLE_PAGES)) begin
                        n_out = '{ST_FULL, 64'd0, 1'b0, 44'd0, 1'b1};
                        n_ovalid = 1'b1;
                    end else begin
                        req.we    = 1'b1;
                        req.wdata = {10'd0, r_base + 44'(r_nfp), 10'd1};
                        n_page    = r_nfp[PAGE_W-1:0];
                        n_nfp     = r_nfp + 1'b1;
                        n_lvl     = r_lvl - 1'b1;
                        n_state   = S_RD;
                    end
                end else begin
                    n_ovalid = 1'b1;
                    n_out.last = (r_i + 1'b1 == r_item.page_count);
                    n_out.freed_valid = 1'b0;
                    n_out.freed_page  = '0;
                    n_out.status = ST_OK;
                    unique case (r_item.op)
                        OP_MAP: begin
                            if (rdata[0]) begin
                                n_out = '{ST_REMAP, 64'd0, 1'b0, 44'd0, 1'b1};
                            end else begin
                                req.we = 1'b1;
                                req.wdata = {10'd0, r_item.pa_page + 44'(r_i),
                                             2'b00, r_item.perm | 8'h01};
                                n_out.entry_value = req.wdata;
                            end
                        end
                        OP_UNMAP: begin
                            if (!rdata[0]) begin
                                n_out = '{ST_UNMAPPED, 64'd0, 1'b0, 44'd0, 1'b1};
                            end else if (rdata[3:1] == 3'd0) begin
                                n_out = '{ST_NOTLEAF, 64'd0, 1'b0, 44'd0, 1'b1};
                            end else begin
                                req.we = 1'b1;
                                n_out.entry_value = rdata;
                                n_out.freed_valid = r_item.free_it;
                                n_out.freed_page  = r_item.free_it ? e_ppn : 44'd0;
                            end
                        end
                        default: begin
                            n_out.entry_value = rdata;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    if (r_out.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_lvl   = 2'd2;
                        n_page  = '0;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
